// ----- hw/rtl/bdtw_pkg.sv -----
// shared constants, types and controller/datapath command bundles for the dtw matcher
// used by all modules of banded_dtw_gesture_match
package bdtw_pkg;
   localparam int MAX_FRAMES = 64;
   localparam int FEATURES   = 15;
   localparam int FRAME_W    = 6;
   localparam int FEAT_W     = 4;
   localparam int ADDR_W     = 10;
   localparam int STORE_DEPTH = MAX_FRAMES * FEATURES;
   localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

   localparam logic [1:0] CSR_TEMPLATE_LENGTH = 2'd0;
   localparam logic [1:0] CSR_BAND_WIDTH      = 2'd1;
   localparam logic [1:0] CSR_MATCH_THRESHOLD = 2'd2;

   localparam logic REQ_TEMPLATE = 1'b0;
   localparam logic REQ_QUERY    = 1'b1;

   // controller to datapath, one cell at a time
   typedef struct packed {
      logic                  clear_acc;   // start a new cost accumulation
      logic                  rd_en;       // read one feature pair
      logic [FRAME_W-1:0]    t_frame;
      logic [FRAME_W-1:0]    q_frame;
      logic [FEAT_W-1:0]     feat;
      logic                  acc_en;      // add the read pair into the sum
      logic                  sqrt_start;
      logic                  cell_en;     // write the finished cell
      logic [FRAME_W-1:0]    cell_i;
      logic                  col_sel;     // which column is current
      logic                  cell_kind_origin;
      logic                  cell_kind_edge_col; // first query column (j=0)
      logic                  cell_kind_edge_row; // i=0 cell of a later column
      logic                  cell_in_band;
      logic                  capture_result;
   } bdtw_cmd_type;

   typedef struct packed {
      logic sqrt_busy;
      logic sqrt_done;
   } bdtw_sts_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? SAT_MAX : s[31:0];
   endfunction
endpackage

// ----- hw/rtl/bdtw_isqrt.sv -----
// iterative integer square root, two bits of radicand per cycle
// depends on bdtw_pkg
module bdtw_isqrt import bdtw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [35:0] radicand,
   output logic        busy,
   output logic        done,
   output logic [17:0] root
);
   logic [35:0] x_ff, x_in;
   logic [35:0] res_ff, res_in;
   logic [35:0] bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   always_comb begin
      x_in = x_ff; res_in = res_ff; bit_in = bit_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         x_in = radicand; res_in = '0; bit_in = 36'h4_0000_0000; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (x_ff >= res_ff + bit_ff) begin
            x_in = x_ff - (res_ff + bit_ff);
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; res_ff <= res_in; bit_ff <= bit_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = res_ff[17:0];
endmodule

// ----- hw/rtl/bdtw_datapath.sv -----
// feature stores, squared-difference accumulator, square root and cost columns
// depends on bdtw_pkg and bdtw_isqrt
module bdtw_datapath import bdtw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic               wr_query,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [15:0]        wr_data,
   input  bdtw_cmd_type       cmd,
   input  logic [31:0]        match_threshold,
   output bdtw_sts_type       sts,
   output logic [31:0]        warp_distance,
   output logic               matched
);
   logic [15:0] tmem [STORE_DEPTH];
   logic [15:0] qmem [STORE_DEPTH];
   logic [31:0] col_mem [2*MAX_FRAMES];
   logic [15:0] t_rd_ff, q_rd_ff;
   logic [35:0] acc_ff, acc_in;
   logic [ADDR_W-1:0] t_addr, q_addr;
   logic [16:0] diff;
   logic [16:0] adiff;
   logic [33:0] sq;
   logic [17:0] root;
   logic [31:0] c1, c2;
   logic [31:0] left_ff, diag_ff, up_ff;
   logic [31:0] cell_val;
   logic [31:0] m1, m2;
   logic [31:0] dist_ff;
   logic        match_ff;
   logic [6:0]  left_idx, prev_idx, prev_dm1_idx;
   logic [31:0] prev_rd_ff, prevm1_rd_ff;

   assign t_addr = ADDR_W'(cmd.t_frame * FEATURES) + ADDR_W'(cmd.feat);
   assign q_addr = ADDR_W'(cmd.q_frame * FEATURES) + ADDR_W'(cmd.feat);

   always_ff @(posedge clock) begin
      if (wr_en && !wr_query) tmem[wr_addr] <= wr_data;
      if (wr_en && wr_query)  qmem[wr_addr] <= wr_data;
      if (cmd.rd_en) begin
         t_rd_ff <= tmem[t_addr];
         q_rd_ff <= qmem[q_addr];
      end
   end

   assign diff  = {t_rd_ff[15], t_rd_ff} - {q_rd_ff[15], q_rd_ff};
   assign adiff = diff[16] ? (17'd0 - diff) : diff;
   assign sq    = adiff * adiff;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.clear_acc) acc_in = '0;
      else if (cmd.acc_en) acc_in = acc_ff + 36'(sq);
   end

   always_ff @(posedge clock) acc_ff <= acc_in;

   bdtw_isqrt u_isqrt (
      .clock(clock), .reset(reset), .start(cmd.sqrt_start), .radicand(acc_ff),
      .busy(sts.sqrt_busy), .done(sts.sqrt_done), .root(root)
   );

   // previous column reads: prev[i] and prev[i-1], prefetched while the root iterates
   assign prev_idx     = {~cmd.col_sel, cmd.cell_i};
   assign prev_dm1_idx = {~cmd.col_sel, cmd.cell_i - FRAME_W'(1)};
   assign left_idx     = {cmd.col_sel, cmd.cell_i};
   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         prev_rd_ff   <= col_mem[prev_idx];
         prevm1_rd_ff <= col_mem[prev_dm1_idx];
      end
   end

   assign c1 = 32'(root);
   assign c2 = sat_add(c1, c1);

   always_comb begin
      up_ff   = prev_rd_ff;
      diag_ff = prevm1_rd_ff;
      m1 = sat_add(left_ff, c1);
      m2 = sat_add(diag_ff, c2);
      if (m2 < m1) m1 = m2;
      m2 = sat_add(up_ff, c1);
      if (m2 < m1) m1 = m2;
      priority if (!cmd.cell_in_band)       cell_val = SAT_MAX;
      else if (cmd.cell_kind_origin)        cell_val = c2;
      else if (cmd.cell_kind_edge_col)      cell_val = sat_add(left_ff, c1);
      else if (cmd.cell_kind_edge_row)      cell_val = sat_add(up_ff, c1);
      else                                  cell_val = m1;
   end

   always_ff @(posedge clock) begin
      if (cmd.cell_en) begin
         col_mem[left_idx] <= cell_val;
         left_ff <= cell_val;
      end
      if (cmd.capture_result) begin
         dist_ff  <= left_ff;
         match_ff <= left_ff < match_threshold;
      end
   end

   assign warp_distance = dist_ff;
   assign matched       = match_ff;
endmodule

// ----- hw/rtl/bdtw_ctrl.sv -----
// sequencer that walks the whole grid cell by cell and drives the datapath
// depends on bdtw_pkg
module bdtw_ctrl import bdtw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [6:0]         m_len,
   input  logic [6:0]         n_len,
   input  logic [6:0]         band_r,
   input  bdtw_sts_type       sts,
   input  logic               out_free,
   output bdtw_cmd_type       cmd,
   output logic               busy,
   output logic               result_valid
);
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_READ  = 7'b0000010,
      ST_ACC   = 7'b0000100,
      ST_ROOT  = 7'b0001000,
      ST_WAIT  = 7'b0010000,
      ST_CELL  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [FRAME_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [FEAT_W-1:0]  f_ff, f_in;
   logic               col_ff, col_in;
   logic               res_ff, res_in;
   logic [7:0]         lo, hi;
   logic               in_band;
   logic               cell_origin, cell_col0, cell_row0;

   assign cell_origin = (i_ff == '0) && (j_ff == '0);
   assign cell_col0   = (j_ff == '0) && (i_ff != '0);
   assign cell_row0   = (i_ff == '0) && (j_ff != '0);
   assign lo = ({2'b0, j_ff} <= {1'b0, band_r}) ? 8'd0 : ({2'b0, j_ff} - {1'b0, band_r});
   assign hi = {2'b0, j_ff} + {1'b0, band_r};
   always_comb begin
      if (cell_origin) in_band = 1'b1;
      else if (cell_col0 || cell_row0)
         in_band = ({2'b0, i_ff} + {2'b0, j_ff}) <= {1'b0, band_r};
      else in_band = ({2'b0, i_ff} >= lo) && ({2'b0, i_ff} <= hi);
   end

   always_comb begin
      state_in = state_ff; i_in = i_ff; j_in = j_ff; f_in = f_ff;
      col_in = col_ff; res_in = res_ff;
      cmd = '0;
      cmd.t_frame = i_ff; cmd.q_frame = j_ff; cmd.feat = f_ff;
      cmd.cell_i = i_ff; cmd.col_sel = col_ff;
      cmd.cell_kind_origin = cell_origin;
      cmd.cell_kind_edge_col = cell_col0;
      cmd.cell_kind_edge_row = cell_row0;
      cmd.cell_in_band = in_band;
      if (out_free) res_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               i_in = '0; j_in = '0; f_in = '0; col_in = 1'b0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.clear_acc = (f_ff == '0);
            cmd.rd_en = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            if (f_ff == FEAT_W'(FEATURES - 1)) begin
               f_in = '0; state_in = ST_ROOT;
            end else begin
               f_in = f_ff + FEAT_W'(1);
               cmd.rd_en = 1'b1;
               cmd.feat = f_ff + FEAT_W'(1);
               state_in = ST_ACC;
            end
         end
         ST_ROOT: begin
            cmd.sqrt_start = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (sts.sqrt_done) state_in = ST_CELL;
         end
         ST_CELL: begin
            cmd.cell_en = 1'b1;
            if ({1'b0, i_ff} == m_len - 7'd1) begin
               i_in = '0;
               if ({1'b0, j_ff} == n_len - 7'd1) state_in = ST_DONE;
               else begin
                  j_in = j_ff + FRAME_W'(1); col_in = ~col_ff; state_in = ST_READ;
               end
            end else begin
               i_in = i_ff + FRAME_W'(1); state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (!res_ff || out_free) begin
               cmd.capture_result = 1'b1; res_in = 1'b1; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in; j_ff <= j_in; f_ff <= f_in; col_ff <= col_in;
      if (reset) begin
         state_ff <= ST_IDLE; res_ff <= 1'b0;
      end else begin
         state_ff <= state_in; res_ff <= res_in;
      end
   end

   assign busy = state_ff != ST_IDLE;
   assign result_valid = res_ff;
endmodule

// ----- hw/rtl/banded_dtw_gesture_match.sv -----
// Banded DTW gesture matcher. A query element with last_of_query starts a run that
// evaluates every cell of the m x n grid (template frames by query frames): each cell
// streams its 15 feature pairs from the stores, starts and iterates the square root and
// then writes the cell; no new item is accepted during a run or while a finished run
// waits for the output register. Out-of-band cells still cost the full walk.
// Depends on bdtw_pkg, bdtw_ctrl, bdtw_datapath.
module banded_dtw_gesture_match import bdtw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // frame_index[5:0], feature_index[9:6], feature_value[25:10]
   input  logic        req_tuser,  // req_type
   input  logic        req_tlast,  // last_of_query
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // warp_distance[31:0]
   output logic        rsp_tuser,  // matched
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   logic [6:0]  tlen_ff;
   logic [5:0]  band_ff;
   logic [31:0] thr_ff;
   logic        req_xfer;
   logic [5:0]  frame;
   logic [3:0]  feat;
   logic        wr_ok;
   logic        run_start;
   logic [6:0]  m_len, n_len, mn_diff;
   logic [6:0]  m_ff, n_ff, r_ff;
   logic [6:0]  r_in;
   bdtw_cmd_type cmd;
   bdtw_sts_type sts;
   logic        busy, start_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         tlen_ff <= 7'd64; band_ff <= 6'd2; thr_ff <= 32'd256000;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TEMPLATE_LENGTH: tlen_ff <= csr_data[6:0];
            CSR_BAND_WIDTH:      band_ff <= csr_data[5:0];
            CSR_MATCH_THRESHOLD: thr_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_tready = !busy && !start_ff;
   assign req_xfer = req_tvalid && req_tready;
   assign frame = req_tdata[5:0];
   assign feat  = req_tdata[9:6];
   assign wr_ok = req_xfer && (feat < FEAT_W'(FEATURES));
   assign run_start = req_xfer && (req_tuser == REQ_QUERY) && req_tlast;

   assign m_len = (tlen_ff == 7'd0) ? 7'd1 : ((tlen_ff > 7'd64) ? 7'd64 : tlen_ff);
   assign n_len = {1'b0, frame} + 7'd1;
   assign mn_diff = (m_len > n_len) ? (m_len - n_len) : (n_len - m_len);
   assign r_in = {1'b0, band_ff} + mn_diff;

   always_ff @(posedge clock) begin
      if (run_start) begin
         m_ff <= m_len; n_ff <= n_len; r_ff <= r_in;
      end
      if (reset) start_ff <= 1'b0;
      else start_ff <= run_start;
   end

   bdtw_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start_ff), .m_len(m_ff), .n_len(n_ff),
      .band_r(r_ff), .sts(sts), .out_free(rsp_tready), .cmd(cmd), .busy(busy),
      .result_valid(rsp_tvalid)
   );

   bdtw_datapath u_dp (
      .clock(clock), .reset(reset), .wr_en(wr_ok), .wr_query(req_tuser),
      .wr_addr(ADDR_W'(frame * FEATURES) + ADDR_W'(feat)), .wr_data(req_tdata[25:10]),
      .cmd(cmd), .match_threshold(thr_ff), .sts(sts), .warp_distance(rsp_tdata),
      .matched(rsp_tuser)
   );

   // no new item is taken while a run is walking the grid
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready) else $error("item accepted during run");
   // every run start leads the controller out of idle
   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      start_ff |=> busy) else $error("run did not start");
   // the match flag agrees with the reported distance
   a_match_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && $stable(thr_ff) |-> (rsp_tuser == (rsp_tdata < thr_ff)))
      else $error("match flag disagrees with distance");
endmodule

// ----- sim/tb_top.sv -----
// self-checking bench for banded_dtw_gesture_match: streams template and query elements,
// predicts every banded dtw distance and match flag in-bench and compares each transfer
// depends on bdtw_pkg and the banded_dtw_gesture_match rtl
`timescale 1ns / 100ps

module tb_top;
   import bdtw_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 60;
   localparam int LONG_HOLD = 3000;
   localparam logic [1:0] CSR_SPARE_INDEX = 2'd3;

   typedef struct {
      logic            qry;
      logic [5:0]      frame;
      logic [3:0]      feat;
      logic [15:0]     value;
      logic            last;
   } elem_type;

   typedef struct {
      logic [31:0] dist_val;
      logic        hit;
   } score_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   banded_dtw_gesture_match dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // predictor state
   logic [15:0] tmpl_mem [STORE_DEPTH];
   logic [15:0] qry_mem [STORE_DEPTH];
   logic [6:0]  len_reg = 7'd64;
   logic [5:0]  band_reg = 6'd2;
   logic [31:0] thr_reg = 32'd256000;

   elem_type  pending_elems[$];
   score_type expected_scores[$];
   int     err_cnt = 0;
   int     accepted_elems = 0;
   int     checked_scores = 0;
   int     cycle_cnt = 0;
   bit     quick_mode = 0;
   int     hold_req_cnt = 0;

   function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [31:0] root64(input logic [63:0] x);
      logic [31:0] r;
      logic [63:0] trial;
      r = '0;
      for (int k = 31; k >= 0; k--) begin
         trial = {32'd0, r | (32'd1 << k)};
         if (trial * trial <= x) r = trial[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] frame_cost(input int t, input int q);
      logic [63:0] acc;
      longint      d;
      acc = '0;
      for (int f = 0; f < FEATURES; f++) begin
         d = longint'($signed(tmpl_mem[t*FEATURES+f])) - longint'($signed(qry_mem[q*FEATURES+f]));
         if (d < 0) d = -d;
         acc += 64'(d * d);
      end
      return root64(acc);
   endfunction

   function automatic logic [31:0] warp_distance(input int m, input int n);
      logic [31:0] prv [MAX_FRAMES];
      logic [31:0] nxt [MAX_FRAMES];
      logic [31:0] c, c2, best;
      int          r2, lo, hi;
      r2 = int'(band_reg) + ((m > n) ? m - n : n - m);
      c = frame_cost(0, 0);
      prv[0] = add_sat(c, c);
      for (int i = 1; i < m; i++)
         prv[i] = (i <= r2) ? add_sat(prv[i-1], frame_cost(i, 0)) : SAT_MAX;
      for (int j = 1; j < n; j++) begin
         lo = (j <= r2) ? 1 : j - r2;
         hi = (j + r2 > m - 1) ? m - 1 : j + r2;
         nxt[0] = (j <= r2) ? add_sat(prv[0], frame_cost(0, j)) : SAT_MAX;
         for (int i = 1; i < m; i++) begin
            if (i >= lo && i <= hi) begin
               c = frame_cost(i, j);
               c2 = add_sat(c, c);
               best = add_sat(nxt[i-1], c);
               if (add_sat(prv[i-1], c2) < best) best = add_sat(prv[i-1], c2);
               if (add_sat(prv[i], c) < best) best = add_sat(prv[i], c);
               nxt[i] = best;
            end else begin
               nxt[i] = SAT_MAX;
            end
         end
         prv = nxt;
      end
      return prv[m-1];
   endfunction

   function automatic int eff_len(input logic [6:0] l);
      if (l == 0) return 1;
      if (l > MAX_FRAMES) return MAX_FRAMES;
      return int'(l);
   endfunction

   task automatic absorb_elem(input elem_type e);
      score_type s;
      int     n;
      if (e.feat < FEATURES) begin
         if (e.qry == REQ_QUERY) qry_mem[e.frame*FEATURES+e.feat] = e.value;
         else tmpl_mem[e.frame*FEATURES+e.feat] = e.value;
      end
      if (e.qry == REQ_QUERY && e.last) begin
         n = int'(e.frame) + 1;
         s.dist_val = warp_distance(eff_len(len_reg), n);
         s.hit = s.dist_val < thr_reg;
         expected_scores.push_back(s);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      err_cnt++;
   endtask

   // request driver
   elem_type drv_elem;
   bit    drv_busy = 0;
   int    drv_gap = 0;

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      if (!reset && req_tvalid && req_tready) begin
         absorb_elem(drv_elem);
         accepted_elems++;
         drv_busy = 0;
      end
   end

   always @(negedge clock) begin
      if (!reset && !drv_busy) begin
         if (drv_gap > 0) begin
            drv_gap--;
            req_tvalid <= 0;
         end else if (pending_elems.size() != 0) begin
            drv_elem = pending_elems.pop_front();
            req_tdata <= {6'd0, drv_elem.value, drv_elem.feat, drv_elem.frame};
            req_tuser <= drv_elem.qry;
            req_tlast <= drv_elem.last;
            req_tvalid <= 1;
            drv_busy = 1;
            drv_gap = quick_mode ? 0 : $urandom_range(0, 18);
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // result monitor
   score_type got_exp;
   int     rsp_stall = 0;
   int     hold_seen = 0;
   int     hold_left = 0;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_scores.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_tdata, 32'd0);
         end else begin
            got_exp = expected_scores.pop_front();
            if (rsp_tdata !== got_exp.dist_val)
               report_mismatch("warp_distance", rsp_tdata, got_exp.dist_val);
            if (rsp_tuser !== got_exp.hit)
               report_mismatch("matched", 32'(rsp_tuser), 32'(got_exp.hit));
            checked_scores++;
         end
         rsp_stall = quick_mode ? 0 : $urandom_range(0, 18);
      end
   end

   always @(negedge clock) begin
      if (hold_req_cnt != hold_seen) begin
         hold_seen = hold_req_cnt;
         hold_left = LONG_HOLD;
      end
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   // stimulus generation
   bit tmpl_seen [STORE_DEPTH];
   bit qry_seen [STORE_DEPTH];
   int gen_elems = 0;
   int gen_runs = 0;
   int gen_m = MAX_FRAMES;

   task automatic push_elem(input logic qry, input int fr, input int ft,
                            input logic [15:0] v, input logic lst);
      elem_type e;
      e.qry = qry;
      e.frame = fr[5:0];
      e.feat = ft[3:0];
      e.value = v;
      e.last = lst;
      if (ft < FEATURES) begin
         if (qry == REQ_QUERY) qry_seen[fr*FEATURES+ft] = 1;
         else tmpl_seen[fr*FEATURES+ft] = 1;
      end
      if (qry == REQ_QUERY && lst) gen_runs++;
      pending_elems.push_back(e);
      gen_elems++;
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(0, 1023)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic fill_frames(input logic qry, input int frames);
      for (int fr = 0; fr < frames; fr++)
         for (int ft = 0; ft < FEATURES; ft++)
            if (!(qry == REQ_QUERY ? qry_seen[fr*FEATURES+ft] : tmpl_seen[fr*FEATURES+ft]))
               push_elem(qry, fr, ft, pick_value(), qry == REQ_QUERY ? 1'b0 : 1'($urandom));
   endtask

   task automatic run_gesture(input int n);
      logic qry;
      fill_frames(REQ_TEMPLATE, gen_m);
      fill_frames(REQ_QUERY, n);
      // rewrites inside the loaded region, some with an ignored feature slot
      repeat ($urandom_range(0, 6)) begin
         qry = 1'($urandom);
         push_elem(qry, $urandom_range(0, (qry == REQ_QUERY ? n : gen_m) - 1),
                   $urandom_range(0, 15), pick_value(),
                   qry == REQ_QUERY ? 1'b0 : 1'($urandom));
      end
      push_elem(REQ_QUERY, n - 1, $urandom_range(0, 15), pick_value(), 1'b1);
   endtask

   task automatic settle();
      while (pending_elems.size() != 0 || drv_busy || expected_scores.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_TEMPLATE_LENGTH: begin
            len_reg = data[6:0];
            gen_m = eff_len(data[6:0]);
         end
         CSR_BAND_WIDTH: band_reg = data[5:0];
         CSR_MATCH_THRESHOLD: thr_reg = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic [31:0] pick_threshold();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom_range(0, 3000000);
      endcase
   endfunction

   initial begin
      for (int k = 0; k < STORE_DEPTH; k++) begin
         tmpl_mem[k] = '0;
         qry_mem[k] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: one-frame template, extremes, ignored slots and last marks
      csr_write(CSR_TEMPLATE_LENGTH, 32'd0);
      csr_write(CSR_BAND_WIDTH, 32'd0);
      csr_write(CSR_MATCH_THRESHOLD, 32'd0);
      csr_write(CSR_SPARE_INDEX, 32'hFFFF_FFFF);
      for (int ft = 0; ft < FEATURES; ft++)
         push_elem(REQ_TEMPLATE, 0, ft, ft[0] ? 16'h7FFF : 16'h8000, ft == 3);
      for (int ft = 0; ft < FEATURES - 1; ft++)
         push_elem(REQ_QUERY, 0, ft, ft[0] ? 16'h8000 : 16'h7FFF, 1'b0);
      push_elem(REQ_QUERY, 0, FEATURES - 1, 16'h0000, 1'b1);
      push_elem(REQ_QUERY, 0, 15, 16'h1234, 1'b1);
      push_elem(REQ_TEMPLATE, 63, 15, 16'hFFFF, 1'b1);
      settle();
      csr_write(CSR_MATCH_THRESHOLD, 32'hFFFF_FFFF);
      csr_write(CSR_BAND_WIDTH, 32'd63);
      run_gesture(2);

      // full-size template, length written above the maximum
      settle();
      csr_write(CSR_TEMPLATE_LENGTH, 32'd127);
      csr_write(CSR_BAND_WIDTH, 32'd0);
      run_gesture(2);
      run_gesture(1);
      settle();
      csr_write(CSR_TEMPLATE_LENGTH, 32'd64);
      csr_write(CSR_BAND_WIDTH, 32'd63);
      csr_write(CSR_MATCH_THRESHOLD, 32'd0);
      run_gesture(3);

      // back-pressure: receiver holds off while several runs queue up
      settle();
      csr_write(CSR_TEMPLATE_LENGTH, 32'd2);
      csr_write(CSR_MATCH_THRESHOLD, pick_threshold());
      quick_mode = 1;
      hold_req_cnt++;
      repeat (4) run_gesture($urandom_range(1, 3));

      while (gen_elems < 1750 || gen_runs < 60) begin
         settle();
         quick_mode = ($urandom_range(0, 3) == 0);
         csr_write(CSR_TEMPLATE_LENGTH, $urandom_range(0, 5));
         case ($urandom_range(0, 3))
            0: csr_write(CSR_BAND_WIDTH, 32'd0);
            1: csr_write(CSR_BAND_WIDTH, 32'd63);
            default: csr_write(CSR_BAND_WIDTH, $urandom_range(0, 4));
         endcase
         csr_write(CSR_MATCH_THRESHOLD, pick_threshold());
         repeat (6) run_gesture($urandom_range(1, 6));
      end

      settle();
      repeat (200) @(posedge clock);
      $display("covered %0d element transfers and %0d distance checks", accepted_elems,
               checked_scores);
      $display("template lengths 1..64 incl. clipped writes, band 0..63, thresholds 0..max");
      if (err_cnt == 0 && expected_scores.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
